// ----- sv/avsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// avsfd_pkg
// Shared types, constants and helpers for the A/V sync frame delay block.
// ----------------------------------------------------------------------------
package avsfd_pkg;

   localparam int TIME_WIDTH = 48;
   localparam int INT_W      = 66;

   localparam int COEFF_FRAC_BITS_DEF  = 16;
   localparam int FACTOR_FRAC_BITS_DEF = 24;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int THR_W       = 32;
   localparam int COEFF_W     = 16;
   localparam int CNT_W       = 5;

   localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(10000);
   localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(6554);

   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

   typedef enum logic [1:0] {
      OP_SET_AUDIO   = 2'd0,
      OP_START_CYCLE = 2'd1,
      OP_FRAME_DELAY = 2'd2,
      OP_UNUSED      = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_THRESHOLD   = 2'd0,
      CSR_CORRECTION_COEFF = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic signed [TIME_WIDTH-1:0] pts_us;
      logic [TIME_WIDTH-1:0]        now_us;
   } req_type;

   typedef struct packed {
      logic signed [TIME_WIDTH-1:0] delay_us;
      logic                         skip_frame;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAG,
      S_THR,
      S_DIGIT,
      S_POW_LO,
      S_POW_HI,
      S_POW_DRAIN,
      S_POW_COMMIT,
      S_FAC,
      S_FIN,
      S_FIN_DRAIN,
      S_CORR,
      S_SUM,
      S_ELAPSED,
      S_RESULT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_MAG,
      DP_PASS,
      DP_DIGIT,
      DP_POW_INIT,
      DP_POW_COMMIT,
      DP_FAC,
      DP_CORR,
      DP_SUM,
      DP_ELAPSED,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      logic       take;
      dp_op_type  op;
      logic       mul_clear;
      logic       mul_issue;
      logic       mul_final;
      logic [1:0] mul_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic mag_above;
      logic digit_more;
      logic cnt_last;
      logic out_free;
   } dp_status_type;

   // saturate a wide signed value to 64 bits
   function automatic logic signed [63:0] sat64(input logic signed [INT_W-1:0] v);
      if (&v[INT_W-1:63] || ~|v[INT_W-1:63]) begin
         return v[63:0];
      end else if (v[INT_W-1]) begin
         return S64_MIN;
      end else begin
         return S64_MAX;
      end
   endfunction

   function automatic logic signed [INT_W-1:0] sx64(input logic signed [63:0] v);
      return {{(INT_W-64){v[63]}}, v};
   endfunction

   function automatic logic signed [INT_W-1:0] sxt(input logic signed [TIME_WIDTH-1:0] v);
      return {{(INT_W-TIME_WIDTH){v[TIME_WIDTH-1]}}, v};
   endfunction

   function automatic logic [INT_W-1:0] zxt(input logic [TIME_WIDTH-1:0] v);
      return {{(INT_W-TIME_WIDTH){1'b0}}, v};
   endfunction

   // powers of ten; above the 64-bit range every compare fails
   function automatic logic [63:0] pow10(input logic [CNT_W-1:0] k);
      logic [63:0] r;
      case (k)
         5'd0:  r = 64'd1;
         5'd1:  r = 64'd10;
         5'd2:  r = 64'd100;
         5'd3:  r = 64'd1000;
         5'd4:  r = 64'd10000;
         5'd5:  r = 64'd100000;
         5'd6:  r = 64'd1000000;
         5'd7:  r = 64'd10000000;
         5'd8:  r = 64'd100000000;
         5'd9:  r = 64'd1000000000;
         5'd10: r = 64'd10000000000;
         5'd11: r = 64'd100000000000;
         5'd12: r = 64'd1000000000000;
         5'd13: r = 64'd10000000000000;
         5'd14: r = 64'd100000000000000;
         5'd15: r = 64'd1000000000000000;
         5'd16: r = 64'd10000000000000000;
         5'd17: r = 64'd100000000000000000;
         5'd18: r = 64'd1000000000000000000;
         5'd19: r = 64'd10000000000000000000;
         default: r = '1;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/avsfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// avsfd_ctrl
// Sequencer for the frame delay request: threshold check, digit count,
// power loop on the shared multiplier, final scaling and result.
// ----------------------------------------------------------------------------
module avsfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_opcode,
   output logic                   req_stall,
   input  avsfd_pkg::dp_status_type status,
   output avsfd_pkg::dp_cmd_type    cmd
);
   import avsfd_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [1:0]     sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      req_stall     = (state_ff != S_IDLE);
      cmd.take      = 1'b0;
      cmd.op        = DP_NOP;
      cmd.mul_clear = 1'b0;
      cmd.mul_issue = 1'b0;
      cmd.mul_final = 1'b0;
      cmd.mul_sel   = 2'd0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_opcode == OP_FRAME_DELAY) begin
                  state_in = S_MAG;
               end
            end
         end
         S_MAG: begin
            cmd.op   = DP_MAG;
            state_in = S_THR;
         end
         S_THR: begin
            if (status.mag_above) begin
               state_in = S_DIGIT;
            end else begin
               cmd.op   = DP_PASS;
               state_in = S_SUM;
            end
         end
         S_DIGIT: begin
            if (status.digit_more) begin
               cmd.op = DP_DIGIT;
            end else begin
               cmd.op   = DP_POW_INIT;
               state_in = S_POW_LO;
            end
         end
         S_POW_LO: begin
            cmd.mul_clear = 1'b1;
            cmd.mul_issue = 1'b1;
            cmd.mul_sel   = 2'd0;
            state_in      = S_POW_HI;
         end
         S_POW_HI: begin
            cmd.mul_issue = 1'b1;
            cmd.mul_sel   = 2'd2;
            state_in      = S_POW_DRAIN;
         end
         S_POW_DRAIN: begin
            state_in = S_POW_COMMIT;
         end
         S_POW_COMMIT: begin
            cmd.op   = DP_POW_COMMIT;
            state_in = status.cnt_last ? S_FAC : S_POW_LO;
         end
         S_FAC: begin
            cmd.op   = DP_FAC;
            sel_in   = 2'd0;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.mul_clear = (sel_ff == 2'd0);
            cmd.mul_issue = 1'b1;
            cmd.mul_final = 1'b1;
            cmd.mul_sel   = sel_ff;
            sel_in        = sel_ff + 2'd1;
            if (sel_ff == 2'd3) begin
               state_in = S_FIN_DRAIN;
            end
         end
         S_FIN_DRAIN: begin
            state_in = S_CORR;
         end
         S_CORR: begin
            cmd.op   = DP_CORR;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = DP_SUM;
            state_in = S_ELAPSED;
         end
         S_ELAPSED: begin
            cmd.op   = DP_ELAPSED;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (status.out_free) begin
               cmd.op   = DP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_take_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> state_ff == S_IDLE && !req_stall)
      else $error("request taken while busy");

endmodule

// ----- sv/avsfd_datapath.sv -----
// ----------------------------------------------------------------------------
// avsfd_datapath
// Timing state, configuration registers, shared 32x32 multiplier with
// 128-bit accumulator, correction arithmetic and result register.
// ----------------------------------------------------------------------------
module avsfd_datapath #(
   parameter int COEFF_FRAC_BITS  = avsfd_pkg::COEFF_FRAC_BITS_DEF,
   parameter int FACTOR_FRAC_BITS = avsfd_pkg::FACTOR_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  avsfd_pkg::req_type                    req_data,
   input  avsfd_pkg::dp_cmd_type                 cmd,
   output avsfd_pkg::dp_status_type              status,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [avsfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [avsfd_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output avsfd_pkg::rsp_type                    rsp_data
);
   import avsfd_pkg::*;

   localparam logic [63:0] ONE = 64'(1) << FACTOR_FRAC_BITS;

   logic [THR_W-1:0]              thr_ff;
   logic [COEFF_W-1:0]            coeff_ff;
   logic signed [TIME_WIDTH-1:0]  audio_ff;
   logic signed [TIME_WIDTH-1:0]  prev_ff;
   logic [TIME_WIDTH-1:0]         start_ff;
   logic                          started_ff;
   logic [TIME_WIDTH-1:0]         now_ff;

   logic signed [63:0] diff_ff, gap_ff, corr_ff, sum_ff, el_ff;
   logic [63:0]        mag_ff, p_ff;
   logic [CNT_W-1:0]   cnt_ff, k_ff;

   logic [63:0]  prod_ff;
   logic [1:0]   shift_ff;
   logic         prod_vld_ff;
   logic [127:0] acc_ff, acc_in, acc_add;

   logic         rsp_valid_ff;
   rsp_type      rsp_ff;

   logic [63:0]  base, mul_a, mul_b, prod_in, p_sat, r_sat;
   logic [31:0]  a_half, b_half;
   logic [127:0] acc_pow, acc_fin;
   logic signed [63:0] corr_in;
   logic signed [INT_W-1:0] delay_wide;
   logic signed [TIME_WIDTH-1:0] delay_clamp;
   logic         skip;

   // configuration and timing state
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= THR_RESET;
         coeff_ff   <= COEFF_RESET;
         audio_ff   <= '0;
         prev_ff    <= '0;
         start_ff   <= '0;
         started_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SYNC_THRESHOLD:   thr_ff   <= csr_data[THR_W-1:0];
               CSR_CORRECTION_COEFF: coeff_ff <= csr_data[COEFF_W-1:0];
               default: ;
            endcase
         end
         if (cmd.take) begin
            unique case (req_data.opcode)
               OP_SET_AUDIO: begin
                  audio_ff <= req_data.pts_us;
               end
               OP_START_CYCLE: begin
                  start_ff   <= req_data.now_us;
                  started_ff <= 1'b1;
               end
               OP_FRAME_DELAY: begin
                  prev_ff <= req_data.pts_us;
                  if (!started_ff) begin
                     start_ff   <= req_data.now_us;
                     started_ff <= 1'b1;
                  end
               end
               OP_UNUSED: ;
               default: ;
            endcase
         end
      end
   end

   assign csr_ready = 1'b1;

   // multiplier operands and result shaping
   always_comb begin
      base     = (64'(1) << COEFF_FRAC_BITS) + 64'(coeff_ff);
      mul_a    = cmd.mul_final ? mag_ff : p_ff;
      mul_b    = cmd.mul_final ? p_ff : base;
      a_half   = cmd.mul_sel[1] ? mul_a[63:32] : mul_a[31:0];
      b_half   = cmd.mul_sel[0] ? mul_b[63:32] : mul_b[31:0];
      prod_in  = 64'(a_half) * 64'(b_half);

      case (shift_ff)
         2'd0:    acc_add = {64'b0, prod_ff};
         2'd1:    acc_add = {32'b0, prod_ff, 32'b0};
         2'd2:    acc_add = {prod_ff, 64'b0};
         default: acc_add = '0;
      endcase
      if (cmd.mul_clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + acc_add;
      end else begin
         acc_in = acc_ff;
      end

      acc_pow = acc_ff >> COEFF_FRAC_BITS;
      p_sat   = (|acc_pow[127:64]) ? '1 : acc_pow[63:0];
      acc_fin = acc_ff >> FACTOR_FRAC_BITS;
      r_sat   = (|acc_fin[127:64]) ? '1 : acc_fin[63:0];

      if (diff_ff[63]) begin
         corr_in = r_sat[63] ? S64_MIN : $signed(64'd0 - r_sat);
      end else begin
         corr_in = r_sat[63] ? S64_MAX : $signed(r_sat);
      end

      delay_wide = sx64(sum_ff) - sx64(el_ff);
      if (&delay_wide[INT_W-1:TIME_WIDTH-1] || ~|delay_wide[INT_W-1:TIME_WIDTH-1]) begin
         delay_clamp = delay_wide[TIME_WIDTH-1:0];
      end else if (delay_wide[INT_W-1]) begin
         delay_clamp = {1'b1, {(TIME_WIDTH-1){1'b0}}};
      end else begin
         delay_clamp = {1'b0, {(TIME_WIDTH-1){1'b1}}};
      end
      skip = !(gap_ff > 64'sd0 && sum_ff > 64'sd0);
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         now_ff  <= req_data.now_us;
         diff_ff <= sat64(sxt(req_data.pts_us) - sxt(audio_ff));
         gap_ff  <= sat64(sxt(req_data.pts_us) - sxt(prev_ff));
      end
      if (cmd.mul_issue) begin
         prod_ff  <= prod_in;
         shift_ff <= 2'(cmd.mul_sel[1]) + 2'(cmd.mul_sel[0]);
      end
      acc_ff <= acc_in;
      unique case (cmd.op)
         DP_MAG: begin
            mag_ff <= diff_ff[63] ? 64'd0 - diff_ff : diff_ff;
            cnt_ff <= CNT_W'(1) + CNT_W'(diff_ff[63]);
            k_ff   <= CNT_W'(1);
         end
         DP_PASS:       corr_ff <= diff_ff;
         DP_DIGIT: begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            k_ff   <= k_ff + CNT_W'(1);
         end
         DP_POW_INIT:   p_ff <= ONE;
         DP_POW_COMMIT: begin
            p_ff   <= p_sat;
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         DP_FAC:        p_ff <= p_ff - ONE;
         DP_CORR:       corr_ff <= corr_in;
         DP_SUM:        sum_ff <= sat64(sx64(gap_ff) + sx64(corr_ff));
         DP_ELAPSED:    el_ff <= sat64(zxt(now_ff) - zxt(start_ff));
         DP_RESULT: begin
            rsp_ff.skip_frame <= skip;
            rsp_ff.delay_us   <= skip ? '0 : delay_clamp;
         end
         DP_NOP: ;
         default: ;
      endcase
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul_issue;
         if (cmd.op == DP_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.mag_above  = mag_ff > 64'(thr_ff);
   assign status.digit_more = mag_ff >= pow10(k_ff);
   assign status.cnt_last   = (cnt_ff == CNT_W'(1));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_result_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_RESULT |-> status.out_free)
      else $error("result loaded over an unaccepted response");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op == DP_RESULT))
      else $error("response raised without a result");

   a_pow_count: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_POW_COMMIT |-> cnt_ff != '0)
      else $error("power step with zero count");

   a_clear_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_clear |-> !prod_vld_ff)
      else $error("accumulator cleared with a product in flight");

   a_pow_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_POW_COMMIT |=> p_ff >= $past(p_ff))
      else $error("power decreased");

endmodule

// ----- sv/av_sync_frame_delay.sv -----
// ----------------------------------------------------------------------------
// av_sync_frame_delay
// Audio/video frame delay calculator with dynamic clock-drift correction.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_stall carrying opcode, pts_us and now_us.
// Set-audio-clock, start-cycle and the unused opcode are taken without
// leaving idle and give no response. A frame delay request gives one
// response on rsp_valid/rsp_stall (delay_us, skip_frame).
// A frame delay request with |diff| within the threshold uses diff
// unscaled. Else the digit counter (one power of ten a cycle) finds n,
// the decimal character count of diff, sign included, and the single
// 32x32 multiplier raises (1 + coefficient) to the n-th power: two
// partial products per power step, four for the final scaling.
// One request is worked on at a time; req_stall is high
// while busy. A finished response sits in the output register, so the
// next request is taken while it waits; a further result waits until the
// receiver drops rsp_stall. Reset (synchronous) clears the clocks, the
// cycle-started flag and the response, and restores the threshold and
// coefficient registers. csr writes are taken at any time (csr_ready high).
// ----------------------------------------------------------------------------
module av_sync_frame_delay #(
   parameter int COEFF_FRAC_BITS  = avsfd_pkg::COEFF_FRAC_BITS_DEF,
   parameter int FACTOR_FRAC_BITS = avsfd_pkg::FACTOR_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  avsfd_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output avsfd_pkg::rsp_type                rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [avsfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [avsfd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import avsfd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   avsfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   avsfd_datapath #(
      .COEFF_FRAC_BITS  (COEFF_FRAC_BITS),
      .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the A/V sync frame delay block.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver. A bit-accurate predictor runs on
// every accepted request and keeps the expected responses in a queue. The
// response monitor checks each field against the oldest entry. The run starts
// with a short directed set. Random phases follow, each under its own
// threshold and coefficient setting, with bursty idling on both channels in
// all but the last phase and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
   import avsfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 150;
   localparam int PHASE_ITEMS    = 258;

   localparam logic signed [63:0] SAT_HI  = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SAT_LO  = {1'b1, {63{1'b0}}};
   localparam logic signed [63:0] DLY_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] DLY_MIN = -64'sh0000_8000_0000_0000;
   localparam logic [47:0]        T_MAX   = {48{1'b1}};
   localparam logic [47:0]        PTS_MAX = {1'b0, {47{1'b1}}};
   localparam logic [47:0]        PTS_MIN = {1'b1, {47{1'b0}}};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SYNC_THRESHOLD;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // predictor state and register copies
   logic [31:0]        sync_thr   = 32'd10000;
   logic [15:0]        drift_coef = 16'd6554;
   logic signed [63:0] audio_clk  = '0;
   logic signed [63:0] last_pts   = '0;
   logic [47:0]        cycle_t0   = '0;
   logic               cycle_on   = 1'b0;

   req_type req_q[$];
   rsp_type delay_q[$];
   int      mismatches = 0;
   int      item_cnt   = 0;
   int      req_gap    = 0;
   int      stall_gap  = 0;
   int      long_hold  = 0;
   int      quiet_cycles = 0;
   bit      idle_on    = 1'b1;
   bit      req_taken  = 1'b0;

   av_sync_frame_delay dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic signed [65:0] sx66(logic signed [63:0] v);
      return {{2{v[63]}}, v};
   endfunction

   function automatic logic signed [63:0] clamp64(logic signed [65:0] v);
      if (v[65:63] == 3'b000 || v[65:63] == 3'b111) return v[63:0];
      return v[65] ? SAT_LO : SAT_HI;
   endfunction

   function automatic logic [63:0] abs64(logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // diff scaled by ((1 + c)^n - 1), n = decimal characters of diff
   function automatic logic signed [63:0] drift_correct(logic signed [63:0] diff);
      logic [63:0]  mag, t, p, q, rem, fac, r;
      logic [127:0] prod;
      logic [16:0]  base;
      int           n, i;
      bit           sat;
      mag = abs64(diff);
      t   = mag;
      n   = 1;
      while (t >= 64'd10) begin
         t = t / 64'd10;
         n++;
      end
      if (diff < 0) n++;
      base = 17'h10000 + {1'b0, drift_coef};
      p    = 64'h1 << 24;
      sat  = 1'b0;
      for (i = 0; i < n && !sat; i++) begin
         q    = p >> 16;
         rem  = p & 64'hFFFF;
         prod = {64'b0, q} * 128'(base);
         if (prod[127:64] != '0) begin
            p   = '1;
            sat = 1'b1;
         end else begin
            rem = (rem * 64'(base)) >> 16;
            p   = (prod[63:0] > ~rem) ? '1 : prod[63:0] + rem;
         end
      end
      fac  = p - (64'h1 << 24);
      prod = {64'b0, mag} * {64'b0, fac};
      r    = (prod[127:88] != '0) ? '1 : prod[87:24];
      if (diff < 0) return (r > 64'(SAT_HI)) ? SAT_LO : -$signed(r);
      return (r > 64'(SAT_HI)) ? SAT_HI : $signed(r);
   endfunction

   function automatic void frame_delay_predict(req_type rq);
      logic signed [63:0] pts, diff, gap, sum, elapsed, dly;
      logic [47:0]        now;
      rsp_type            rs;
      pts = {{16{rq.pts_us[47]}}, rq.pts_us};
      now = rq.now_us;
      case (opcode_type'(rq.opcode))
         OP_SET_AUDIO: audio_clk = pts;
         OP_START_CYCLE: begin
            cycle_t0 = now;
            cycle_on = 1'b1;
         end
         OP_FRAME_DELAY: begin
            if (!cycle_on) begin
               cycle_t0 = now;
               cycle_on = 1'b1;
            end
            diff     = clamp64(sx66(pts) - sx66(audio_clk));
            gap      = clamp64(sx66(pts) - sx66(last_pts));
            last_pts = pts;
            if (abs64(diff) > {32'b0, sync_thr}) diff = drift_correct(diff);
            sum = clamp64(sx66(gap) + sx66(diff));
            if (gap > 0 && sum > 0) begin
               if (now >= cycle_t0) elapsed = {16'b0, now - cycle_t0};
               else elapsed = -$signed({16'b0, cycle_t0 - now});
               dly = clamp64(sx66(sum) - sx66(elapsed));
               if (dly > DLY_MAX) dly = DLY_MAX;
               if (dly < DLY_MIN) dly = DLY_MIN;
               rs.delay_us   = dly[47:0];
               rs.skip_frame = 1'b0;
            end else begin
               rs.delay_us   = '0;
               rs.skip_frame = 1'b1;
            end
            delay_q.push_back(rs);
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------ driver
   always @(negedge clock) begin : req_driver
      logic    nxt_valid;
      req_type nxt_data;
      nxt_valid = req_valid;
      nxt_data  = req_data;
      if (req_taken) begin
         req_taken = 1'b0;
         nxt_valid = 1'b0;
         if (idle_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 12);
      end
      if (!nxt_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (req_q.size() != 0) begin
            nxt_data  = req_q.pop_front();
            nxt_valid = 1'b1;
         end
      end
      req_valid <= nxt_valid;
      req_data  <= nxt_data;
   end

   always @(negedge clock) begin : rsp_receiver
      logic nxt_stall;
      if (long_hold > 0) begin
         long_hold--;
         nxt_stall = 1'b1;
      end else if (stall_gap > 0) begin
         stall_gap--;
         nxt_stall = 1'b1;
      end else begin
         nxt_stall = 1'b0;
         if (idle_on && $urandom_range(0, 5) == 0) stall_gap = $urandom_range(1, 12);
      end
      rsp_stall <= nxt_stall;
   end

   // ----------------------------------------------------------------- monitors
   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 200) $display("%0t ERROR %s", $time, msg);
   endtask

   always @(posedge clock) begin : req_monitor
      if (!reset && req_valid && !req_stall) begin
         frame_delay_predict(req_data);
         req_taken = 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (delay_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response delay=%0d skip=%0b",
                                      rsp_data.delay_us, rsp_data.skip_frame));
         end else begin
            want = delay_q.pop_front();
            if (rsp_data.delay_us !== want.delay_us)
               report_mismatch($sformatf("delay_us got %0d want %0d",
                                         rsp_data.delay_us, want.delay_us));
            if (rsp_data.skip_frame !== want.skip_frame)
               report_mismatch($sformatf("skip_frame got %0b want %0b",
                                         rsp_data.skip_frame, want.skip_frame));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ----------------------------------------------------------------- stimulus
   task automatic queue_req(opcode_type op, logic [47:0] pts, logic [47:0] now);
      req_type rq;
      rq.opcode = op;
      rq.pts_us = pts;
      rq.now_us = now;
      req_q.push_back(rq);
      if (op != OP_UNUSED) item_cnt++;
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SYNC_THRESHOLD) sync_thr = val;
      else drift_coef = val[15:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (req_q.size() != 0 || req_valid) @(posedge clock);
      while (delay_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   // signed offset with a random number of decimal digits
   function automatic logic [47:0] rand_offset();
      logic [63:0] lim, m;
      int          k;
      k   = $urandom_range(0, 14);
      lim = 64'd1;
      repeat (k) lim = lim * 64'd10;
      m = {$urandom, $urandom} % lim;
      return $urandom_range(0, 1) ? -m[47:0] : m[47:0];
   endfunction

   function automatic logic [47:0] rand_time();
      logic [47:0] v;
      v = rand48() >> $urandom_range(1, 48);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   // audio set, optional cycle start, then a run of frames
   task automatic gen_session();
      logic [47:0] vid, t;
      int          frames;
      vid = rand_time();
      t   = rand48() >> $urandom_range(0, 24);
      queue_req(OP_SET_AUDIO, vid + rand_offset(), rand48());
      if ($urandom_range(0, 3) != 0) queue_req(OP_START_CYCLE, rand48(), t);
      frames = $urandom_range(2, 10);
      repeat (frames) begin
         case ($urandom_range(0, 9))
            0: vid = vid - ($urandom_range(0, 1) ? rand_offset() : 48'($urandom_range(0, 99999)));
            1: ;
            default: vid = vid + 48'($urandom_range(1, 100000));
         endcase
         t = t + 48'($urandom_range(0, 60000));
         if ($urandom_range(0, 4) == 0) queue_req(OP_SET_AUDIO, vid + rand_offset(), rand48());
         queue_req(OP_FRAME_DELAY, vid, t);
         if ($urandom_range(0, 11) == 0)
            queue_req(opcode_type'($urandom_range(0, 3)), rand48(), rand48());
      end
   endtask

   task automatic run_phase(logic [31:0] thr, logic [15:0] coef, bit idle, int hold);
      int target;
      csr_write(CSR_SYNC_THRESHOLD, thr);
      csr_write(CSR_CORRECTION_COEFF, {16'b0, coef});
      idle_on = idle;
      target  = item_cnt + PHASE_ITEMS;
      while (item_cnt < target) gen_session();
      if (hold > 0) begin
         repeat (40) @(posedge clock);
         long_hold = hold;
      end
      drain();
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset register values
      queue_req(OP_FRAME_DELAY, 48'd40000, 48'd5000);
      queue_req(OP_FRAME_DELAY, 48'd40000, 48'd6000);
      queue_req(OP_SET_AUDIO, 48'd40000, 48'd0);
      queue_req(OP_FRAME_DELAY, 48'd73333, 48'd40000);
      queue_req(OP_SET_AUDIO, 48'd106666, T_MAX);
      queue_req(OP_FRAME_DELAY, 48'd106666, 48'd70000);
      queue_req(OP_UNUSED, rand48(), rand48());
      queue_req(OP_UNUSED, ~48'd0, ~48'd0);
      queue_req(OP_START_CYCLE, 48'd0, T_MAX);
      queue_req(OP_FRAME_DELAY, 48'd140000, 48'd0);
      queue_req(OP_START_CYCLE, PTS_MIN, 48'd0);
      queue_req(OP_FRAME_DELAY, 48'd173333, T_MAX);
      queue_req(OP_SET_AUDIO, PTS_MAX, 48'd0);
      queue_req(OP_FRAME_DELAY, PTS_MIN, 48'd10);
      queue_req(OP_SET_AUDIO, PTS_MIN, 48'd20);
      queue_req(OP_FRAME_DELAY, PTS_MAX, 48'd30);
      queue_req(OP_FRAME_DELAY, ~48'd0, 48'd40);
      queue_req(OP_SET_AUDIO, 48'd1000, 48'd50);
      queue_req(OP_FRAME_DELAY, 48'd500, 48'd60);
      queue_req(OP_SET_AUDIO, 48'd1000000, 48'd70);
      queue_req(OP_FRAME_DELAY, 48'd600, 48'd80);
      queue_req(OP_FRAME_DELAY, 48'd10600, 48'd90);
      drain();

      run_phase(32'd0, 16'd6554, 1'b1, 0);
      run_phase(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 300);
      run_phase(32'd1000, 16'd0, 1'b1, 0);
      run_phase($urandom_range(0, 1000000), 16'($urandom), 1'b1, 0);
      run_phase(32'd33333, 16'hFFFF, 1'b1, 0);
      run_phase(32'd10000, 16'd6554, 1'b0, 0);

      if (mismatches == 0 && delay_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
